@@ rtl/kre_pkg.sv @@
// Package for the key repeat line editor: FSM state type, command, register
// and key codes, reset values and the character filter functions.
// No dependencies.
package kre_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_FILL,
        S_EMIT,
        S_RDOUT
    } t_state;

    localparam int LINE_MAX_DEF = 32;

    localparam logic [1:0] CMD_TICK     = 2'd0;
    localparam logic [1:0] CMD_KEY_DOWN = 2'd1;
    localparam logic [1:0] CMD_KEY_UP   = 2'd2;
    localparam logic [1:0] CMD_BEGIN    = 2'd3;

    localparam logic [1:0] CFG_LINE_LENGTH   = 2'd0;
    localparam logic [1:0] CFG_INIT_DELAY    = 2'd1;
    localparam logic [1:0] CFG_REPEAT_PERIOD = 2'd2;

    localparam logic [6:0] LEN_RST    = 7'd32;
    localparam logic [7:0] DELAY_RST  = 8'd30;
    localparam logic [7:0] PERIOD_RST = 8'd10;

    localparam logic [1:0] CLAMP_NONE  = 2'd0;
    localparam logic [1:0] CLAMP_LEFT  = 2'd1;
    localparam logic [1:0] CLAMP_RIGHT = 2'd2;

    localparam logic [15:0] K_RSHIFT    = 16'd303;
    localparam logic [15:0] K_LSHIFT    = 16'd304;
    localparam logic [15:0] K_RCTRL     = 16'd305;
    localparam logic [15:0] K_LCTRL     = 16'd306;
    localparam logic [15:0] K_LEFT      = 16'd276;
    localparam logic [15:0] K_RIGHT     = 16'd275;
    localparam logic [15:0] K_BACKSPACE = 16'd8;
    localparam logic [15:0] K_DELETE    = 16'd127;
    localparam logic [15:0] K_RETURN    = 16'd13;

    localparam logic [6:0] CH_SPACE    = 7'h20;
    localparam logic [6:0] CH_LOWER_A  = 7'h61;
    localparam logic [6:0] CH_LOWER_Z  = 7'h7a;
    localparam logic [6:0] CASE_OFFSET = 7'd32;

    function automatic logic is_modifier(input logic [15:0] c);
        return c inside {K_LSHIFT, K_RSHIFT, K_LCTRL, K_RCTRL};
    endfunction

    function automatic logic [6:0] to_upper(input logic [6:0] c);
        logic [6:0] r;
        r = c;
        if (c inside {[CH_LOWER_A:CH_LOWER_Z]}) begin
            r = c - CASE_OFFSET;
        end
        return r;
    endfunction

    // space ! - . 0..: A..Z and apostrophe
    function automatic logic char_ok(input logic [6:0] c);
        return c inside {[7'h20:7'h21], [7'h2d:7'h2e], [7'h30:7'h3a],
                         [7'h41:7'h5a], 7'h27};
    endfunction

endpackage

@@ rtl/kre_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module kre_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/key_repeat_line_editor_core.sv @@
// Key repeat line editor: typematic repeat feeding a line buffer held in RAM.
// Depends on kre_pkg and kre_ram.
// A status request goes through S_EMIT, which loads the output register and
// returns to S_IDLE; requests are stalled in every state but S_IDLE.
// Backspace, delete and insert shift the line through the RAM at one entry a
// cycle in S_SHIFT, then write the fill character in S_FILL and go to S_EMIT.
// Return reads the line out in S_RDOUT at one character a cycle while the
// output is not stalled; output stalls also hold S_EMIT.
// Reset (synchronous, active low) loads register defaults and marks every
// line entry as space through per-entry valid bits; no clearing pass.
module key_repeat_line_editor_core
    import kre_pkg::*;
#(
    parameter int LINE_MAX = LINE_MAX_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_key_code,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_key_emitted,
    output logic [5:0]  o_cursor,
    output logic [1:0]  o_cursor_status,
    output logic        o_editing,
    output logic [6:0]  o_char_out,
    output logic        o_char_valid,
    output logic        o_last
);

    localparam int AW = $clog2(LINE_MAX);
    localparam logic [6:0]          LMAX7   = 7'(LINE_MAX);
    localparam logic [AW-1:0]       LMAX_M1 = AW'(LINE_MAX - 1);
    localparam logic signed [AW+1:0] ONE_S  = (AW+2)'(1);

    t_state r_state, n_state;

    logic [6:0]  r_line_length;
    logic [7:0]  r_init_delay, r_rep_period;
    logic [15:0] r_held, n_held, r_repeated, n_repeated;
    logic [7:0]  r_wait, n_wait;
    logic [AW-1:0] r_cursor, n_cursor;
    logic [1:0]  r_clamp, n_clamp;
    logic        r_edit, n_edit;
    logic [15:0] r_emit, emitted;

    logic [AW-1:0] r_addr, r_stop, r_fill_addr, r_pend_addr;
    logic          r_up, r_pend, r_rd_vld, r_rd_ok;
    logic [6:0]    r_fill_data;
    logic [LINE_MAX-1:0] r_ent_vld;

    logic        r_ov, r_o_edit, r_o_cvld, r_o_last;
    logic [15:0] r_o_key;
    logic [5:0]  r_o_cursor;
    logic [1:0]  r_o_clamp;
    logic [6:0]  r_o_char;

    logic          acc, out_free;
    logic [AW-1:0] len_m1;

    // decoded edit operation
    logic          op_shift, op_up, op_fill, op_rdout;
    logic [AW-1:0] op_start, op_stop, op_fill_addr;
    logic [6:0]    op_fill_data, up_c;
    logic [AW:0]   s_dn;
    logic signed [AW+1:0] cur_s, lim_s;

    // RAM and output control
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [6:0]    ram_wdata, ram_q, rd_char;
    logic          out_load, load_cvld, load_last;
    logic [6:0]    load_char;

    kre_ram #(
        .WIDTH (7),
        .DEPTH (LINE_MAX)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    assign acc        = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_ov || !i_out_stall;
    assign rd_char    = r_rd_vld ? ram_q : CH_SPACE;

    always_comb begin
        if (r_line_length == 7'd0) begin
            len_m1 = '0;
        end else if (r_line_length > LMAX7) begin
            len_m1 = LMAX_M1;
        end else begin
            len_m1 = AW'(r_line_length - 7'd1);
        end
    end

    // Request decode: repeat logic and edit step
    always_comb begin
        n_held       = r_held;
        n_repeated   = r_repeated;
        n_wait       = r_wait;
        n_cursor     = r_cursor;
        n_clamp      = r_clamp;
        n_edit       = r_edit;
        emitted      = '0;
        op_shift     = 1'b0;
        op_up        = 1'b0;
        op_fill      = 1'b0;
        op_rdout     = 1'b0;
        op_start     = '0;
        op_stop      = len_m1;
        op_fill_addr = len_m1;
        op_fill_data = CH_SPACE;
        up_c         = to_upper(r_held[6:0]);
        s_dn         = '0;
        cur_s        = $signed({2'b00, r_cursor});
        lim_s        = $signed({2'b00, len_m1});
        case (i_cmd)
            CMD_KEY_DOWN: begin
                if (!is_modifier(i_key_code)) begin
                    n_held = i_key_code;
                end
            end
            CMD_KEY_UP: begin
                if (!is_modifier(i_key_code)) begin
                    if (i_key_code == r_held) begin
                        n_held = '0;
                    end
                    n_wait     = '0;
                    n_repeated = '0;
                end
            end
            CMD_BEGIN: begin
                n_cursor = '0;
                n_edit   = 1'b1;
            end
            default: begin
                if (r_wait == 8'd0) begin
                    emitted = r_held;
                    if (r_held != 16'd0) begin
                        if (r_repeated != r_held) begin
                            n_repeated = r_held;
                            n_wait     = r_init_delay;
                        end else begin
                            n_wait = r_rep_period;
                        end
                    end
                end else begin
                    n_wait = r_wait - 8'd1;
                end
                if (r_edit && emitted != 16'd0) begin
                    n_clamp = CLAMP_NONE;
                    case (emitted)
                        K_LEFT: begin
                            cur_s = cur_s - ONE_S;
                        end
                        K_RIGHT: begin
                            cur_s = cur_s + ONE_S;
                        end
                        K_BACKSPACE: begin
                            s_dn     = (r_cursor != '0) ? {1'b0, r_cursor} : (AW+1)'(1);
                            op_shift = (s_dn <= {1'b0, len_m1});
                            op_start = s_dn[AW-1:0];
                            op_fill  = 1'b1;
                            cur_s    = cur_s - ONE_S;
                        end
                        K_DELETE: begin
                            s_dn     = {1'b0, r_cursor} + (AW+1)'(1);
                            op_shift = (s_dn <= {1'b0, len_m1});
                            op_start = s_dn[AW-1:0];
                            op_fill  = 1'b1;
                        end
                        K_RETURN: begin
                            op_rdout = 1'b1;
                        end
                        default: begin
                            if (char_ok(up_c)) begin
                                op_shift     = (r_cursor < len_m1);
                                op_up        = 1'b1;
                                op_start     = len_m1 - AW'(1);
                                op_stop      = r_cursor;
                                op_fill      = 1'b1;
                                op_fill_addr = r_cursor;
                                op_fill_data = up_c;
                                cur_s        = cur_s + ONE_S;
                            end
                        end
                    endcase
                    if (op_rdout) begin
                        n_cursor = '0;
                        n_edit   = 1'b0;
                    end else if (cur_s < 0) begin
                        n_cursor = '0;
                        n_clamp  = CLAMP_LEFT;
                    end else if (cur_s > lim_s) begin
                        n_cursor = len_m1;
                        n_clamp  = CLAMP_RIGHT;
                    end else begin
                        n_cursor = cur_s[AW-1:0];
                    end
                end
            end
        endcase
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    if (op_rdout) begin
                        n_state = S_RDOUT;
                    end else if (op_shift) begin
                        n_state = S_SHIFT;
                    end else if (op_fill) begin
                        n_state = S_FILL;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_SHIFT: begin
                if (r_addr == r_stop) begin
                    n_state = S_FILL;
                end
            end
            S_FILL: begin
                if (!r_pend) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_RDOUT: begin
                if (r_rd_ok && out_free && r_addr == len_m1) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // RAM port and output register control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_pend_addr;
        ram_wdata = rd_char;
        ram_raddr = r_addr;
        out_load  = 1'b0;
        load_char = '0;
        load_cvld = 1'b0;
        load_last = 1'b1;
        if (r_pend) begin
            ram_we = 1'b1;
        end else if (r_state == S_FILL) begin
            ram_we    = 1'b1;
            ram_waddr = r_fill_addr;
            ram_wdata = r_fill_data;
        end
        case (r_state)
            S_EMIT: begin
                out_load = out_free;
            end
            S_RDOUT: begin
                out_load  = r_rd_ok && out_free;
                load_char = rd_char;
                load_cvld = 1'b1;
                load_last = (r_addr == len_m1);
                ram_raddr = out_load ? r_addr + AW'(1) : r_addr;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_line_length <= LEN_RST;
            r_init_delay  <= DELAY_RST;
            r_rep_period  <= PERIOD_RST;
            r_held        <= '0;
            r_repeated    <= '0;
            r_wait        <= '0;
            r_cursor      <= '0;
            r_clamp       <= CLAMP_NONE;
            r_edit        <= 1'b0;
            r_pend        <= 1'b0;
            r_rd_ok       <= 1'b0;
            r_ent_vld     <= '0;
            r_ov          <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_LENGTH:   r_line_length <= i_cfg_wdata[6:0];
                    CFG_INIT_DELAY:    r_init_delay  <= i_cfg_wdata;
                    CFG_REPEAT_PERIOD: r_rep_period  <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (acc) begin
                r_held     <= n_held;
                r_repeated <= n_repeated;
                r_wait     <= n_wait;
                r_cursor   <= n_cursor;
                r_clamp    <= n_clamp;
                r_edit     <= n_edit;
            end
            r_pend <= (r_state == S_SHIFT);
            if (acc) begin
                r_rd_ok <= 1'b0;
            end else if (r_state == S_RDOUT) begin
                r_rd_ok <= 1'b1;
            end
            if (acc && i_cmd == CMD_BEGIN) begin
                r_ent_vld <= '0;
            end else if (ram_we) begin
                r_ent_vld[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                r_ov <= 1'b1;
            end else if (out_free) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_rd_vld    <= r_ent_vld[ram_raddr];
        r_pend_addr <= r_up ? r_addr + AW'(1) : r_addr - AW'(1);
        if (acc) begin
            r_emit      <= emitted;
            r_addr      <= op_rdout ? '0 : op_start;
            r_stop      <= op_stop;
            r_up        <= op_up;
            r_fill_addr <= op_fill_addr;
            r_fill_data <= op_fill_data;
        end else if (r_state == S_SHIFT) begin
            r_addr <= r_up ? r_addr - AW'(1) : r_addr + AW'(1);
        end else if (r_state == S_RDOUT && out_load) begin
            r_addr <= r_addr + AW'(1);
        end
        if (out_load) begin
            r_o_key    <= r_emit;
            r_o_cursor <= 6'(r_cursor);
            r_o_clamp  <= r_clamp;
            r_o_edit   <= r_edit;
            r_o_char   <= load_char;
            r_o_cvld   <= load_cvld;
            r_o_last   <= load_last;
        end
    end

    assign o_out_valid     = r_ov;
    assign o_key_emitted   = r_o_key;
    assign o_cursor        = r_o_cursor;
    assign o_cursor_status = r_o_clamp;
    assign o_editing       = r_o_edit;
    assign o_char_out      = r_o_char;
    assign o_char_valid    = r_o_cvld;
    assign o_last          = r_o_last;

    a_rdout_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_o_cvld) |-> (!r_o_edit && r_o_cursor == 6'd0))
        else $error("readout result while editing");

    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !r_o_cvld) |-> r_o_last)
        else $error("status result without last");

    a_pend_from_shift: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ($past(r_state) == S_SHIFT))
        else $error("pending write outside shift");

    a_rdout_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RDOUT) |-> (r_addr <= len_m1))
        else $error("readout index beyond line");

endmodule

@@ test/key_repeat_line_editor_core_tb.sv @@
// Self-checking testbench for key_repeat_line_editor_core: typematic repeat and
// line editing checked against an in-bench predictor with random stalls.
// Depends on kre_pkg and the core RTL.
`timescale 1ns / 1ps

module key_repeat_line_editor_core_tb;
    import kre_pkg::*;

    localparam int LINE_MAX = LINE_MAX_DEF;
    localparam logic [15:0] KEY_Z_LOWER = 16'h007a;
    localparam logic [15:0] KEY_QUERY   = 16'h003f;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] key;
    } request_t;

    typedef struct packed {
        logic [15:0] key_emitted;
        logic [5:0]  cursor;
        logic [1:0]  status;
        logic        editing;
        logic [6:0]  char_out;
        logic        char_valid;
        logic        last;
    } edit_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_idx = CFG_LINE_LENGTH;
    logic [7:0]  i_cfg_wdata = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = CMD_TICK;
    logic [15:0] i_key_code = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_key_emitted;
    logic [5:0]  o_cursor;
    logic [1:0]  o_cursor_status;
    logic        o_editing;
    logic [6:0]  o_char_out;
    logic        o_char_valid;
    logic        o_last;

    key_repeat_line_editor_core u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_cmd           (i_cmd),
        .i_key_code      (i_key_code),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_key_emitted   (o_key_emitted),
        .o_cursor        (o_cursor),
        .o_cursor_status (o_cursor_status),
        .o_editing       (o_editing),
        .o_char_out      (o_char_out),
        .o_char_valid    (o_char_valid),
        .o_last          (o_last)
    );

    // predictor state and register copies
    logic [6:0]  cfg_line_len   = LEN_RST;
    logic [7:0]  cfg_init_delay = DELAY_RST;
    logic [7:0]  cfg_repeat     = PERIOD_RST;
    logic [15:0] held_key       = '0;
    logic [15:0] repeat_key     = '0;
    logic [7:0]  wait_ticks     = '0;
    int          edit_col       = 0;
    logic [1:0]  clamp_state    = CLAMP_NONE;
    logic        edit_on        = 1'b0;
    logic [6:0]  line_model [LINE_MAX];

    request_t     key_requests [$];
    edit_result_t expected_results [$];
    int           queued = 0;
    int           errors = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           req_taken = 1'b0;
    bit           quiet = 1'b0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic int line_len_eff();
        int n;
        n = int'(cfg_line_len);
        if (n < 1) n = 1;
        if (n > LINE_MAX) n = LINE_MAX;
        return n;
    endfunction

    function automatic bit modifier_key(input logic [15:0] code);
        return code == K_LSHIFT || code == K_RSHIFT || code == K_LCTRL || code == K_RCTRL;
    endfunction

    function automatic edit_result_t make_result(input logic [15:0] code, input logic [6:0] ch,
                                                 input logic chv, input logic fin);
        edit_result_t r;
        r.key_emitted = code;
        r.cursor      = edit_col[5:0];
        r.status      = clamp_state;
        r.editing     = edit_on;
        r.char_out    = ch;
        r.char_valid  = chv;
        r.last        = fin;
        return r;
    endfunction

    // returns 1 when Return closed the line
    function automatic bit apply_edit(input logic [15:0] code);
        int len, n, from;
        logic [6:0] ch;
        len = line_len_eff();
        clamp_state = CLAMP_NONE;
        case (code)
            K_LEFT: edit_col--;
            K_RIGHT: edit_col++;
            K_BACKSPACE: begin
                // at column zero the shift starts from column one
                from = (edit_col > 0) ? edit_col : 1;
                for (n = from; n < len; n++) line_model[n - 1] = line_model[n];
                line_model[len - 1] = CH_SPACE;
                edit_col--;
            end
            K_DELETE: begin
                for (n = edit_col; n < len - 1; n++) line_model[n] = line_model[n + 1];
                line_model[len - 1] = CH_SPACE;
            end
            K_RETURN: begin
                edit_col = 0;
                edit_on = 1'b0;
                return 1'b1;
            end
            default: begin
                ch = code[6:0];
                if (ch >= CH_LOWER_A && ch <= CH_LOWER_Z) ch = ch - CASE_OFFSET;
                // space ! - . 0..: A..Z and apostrophe
                if ((ch >= 7'h20 && ch <= 7'h21) || (ch >= 7'h2d && ch <= 7'h2e) ||
                    (ch >= 7'h30 && ch <= 7'h3a) || (ch >= 7'h41 && ch <= 7'h5a) ||
                    ch == 7'h27) begin
                    for (n = len - 1; n > edit_col; n--) line_model[n] = line_model[n - 1];
                    if (edit_col >= 0 && edit_col < LINE_MAX) line_model[edit_col] = ch;
                    edit_col++;
                end
            end
        endcase
        if (edit_col < 0) begin
            edit_col = 0;
            clamp_state = CLAMP_LEFT;
        end
        if (edit_col > len - 1) begin
            edit_col = len - 1;
            clamp_state = CLAMP_RIGHT;
        end
        return 1'b0;
    endfunction

    task automatic predict_request(input logic [1:0] cmd, input logic [15:0] key);
        logic [15:0] emitted;
        int len, k;
        emitted = '0;
        case (cmd)
            CMD_KEY_DOWN: begin
                if (!modifier_key(key)) held_key = key;
            end
            CMD_KEY_UP: begin
                if (!modifier_key(key)) begin
                    if (key == held_key) held_key = '0;
                    wait_ticks = '0;
                    repeat_key = '0;
                end
            end
            CMD_BEGIN: begin
                edit_col = 0;
                edit_on = 1'b1;
                for (k = 0; k < LINE_MAX; k++) line_model[k] = CH_SPACE;
            end
            default: begin
                if (wait_ticks == 0) begin
                    emitted = held_key;
                    if (held_key != 0) begin
                        if (repeat_key != held_key) begin
                            repeat_key = held_key;
                            wait_ticks = cfg_init_delay;
                        end else begin
                            wait_ticks = cfg_repeat;
                        end
                    end
                end else begin
                    wait_ticks--;
                end
                if (edit_on && emitted != 0 && apply_edit(emitted)) begin
                    len = line_len_eff();
                    for (k = 0; k < len; k++)
                        expected_results.push_back(make_result(emitted, line_model[k], 1'b1,
                                                               k == len - 1));
                    return;
                end
            end
        endcase
        expected_results.push_back(make_result(emitted, '0, 1'b0, 1'b1));
    endtask

    // sample handshakes, track registers and check results
    always @(posedge i_clk) begin
        edit_result_t got, want;
        if (i_rst_n) begin
            req_taken = i_in_valid && !o_in_stall;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LINE_LENGTH:   cfg_line_len = i_cfg_wdata[6:0];
                    CFG_INIT_DELAY:    cfg_init_delay = i_cfg_wdata;
                    CFG_REPEAT_PERIOD: cfg_repeat = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (req_taken) predict_request(i_cmd, i_key_code);
            if (o_out_valid && !i_out_stall) begin
                got = {o_key_emitted, o_cursor, o_cursor_status, o_editing,
                       o_char_out, o_char_valid, o_last};
                if (expected_results.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: key %0d cur %0d st %0d ed %0b ch %0h/%0b l %0b",
                                 got.key_emitted, got.cursor, got.status, got.editing,
                                 got.char_out, got.char_valid, got.last);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch got: key %0d cur %0d st %0d ed %0b ch %0h/%0b l %0b",
                                     got.key_emitted, got.cursor, got.status, got.editing,
                                     got.char_out, got.char_valid, got.last);
                            $display("    expected: key %0d cur %0d st %0d ed %0b ch %0h/%0b l %0b",
                                     want.key_emitted, want.cursor, want.status, want.editing,
                                     want.char_out, want.char_valid, want.last);
                        end
                    end
                end
            end
        end
    end

    // request driver
    always @(negedge i_clk) begin
        request_t req;
        if (i_rst_n && (!i_in_valid || req_taken)) begin
            if (gap_left > 0 && !quiet) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                gap_left = $urandom_range(0, 16);
                i_in_valid <= 1'b0;
            end else if (key_requests.size() > 0) begin
                req = key_requests.pop_front();
                i_cmd <= req.cmd;
                i_key_code <= req.key;
                i_in_valid <= 1'b1;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // result-side stall
    always @(negedge i_clk) begin
        if (quiet || !i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 16);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic push_req(input logic [1:0] cmd, input logic [15:0] key);
        key_requests.push_back({cmd, key});
        queued++;
    endtask

    // key down, some ticks, key up
    task automatic press_key(input logic [15:0] key, input int ticks);
        push_req(CMD_KEY_DOWN, key);
        repeat (ticks) push_req(CMD_TICK, 16'($urandom));
        push_req(CMD_KEY_UP, key);
    endtask

    function automatic logic [15:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return 16'(CH_LOWER_A) + 16'($urandom_range(0, 25));
        if (r < 42) return 16'($urandom_range(32, 126));
        if (r < 52) return K_LEFT;
        if (r < 62) return K_RIGHT;
        if (r < 70) return K_BACKSPACE;
        if (r < 77) return K_DELETE;
        if (r < 82) return K_RETURN;
        if (r < 86) return K_RSHIFT + 16'($urandom_range(0, 3));
        return 16'($urandom);
    endfunction

    task automatic random_phase(input int n);
        int stop, r;
        stop = queued + n;
        while (queued < stop) begin
            r = $urandom_range(0, 99);
            if (r < 8) push_req(CMD_BEGIN, 16'($urandom));
            else if (r < 60) press_key(pick_key(), 1);
            else if (r < 82) press_key(pick_key(), $urandom_range(2, 8));
            else push_req(2'($urandom_range(0, 3)), 16'($urandom));
        end
    endtask

    task automatic wait_idle();
        while (key_requests.size() != 0 || i_in_valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [7:0] len, input logic [7:0] delay,
                            input logic [7:0] period);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_LINE_LENGTH;
        i_cfg_wdata <= len;
        @(negedge i_clk);
        i_cfg_idx <= CFG_INIT_DELAY;
        i_cfg_wdata <= delay;
        @(negedge i_clk);
        i_cfg_idx <= CFG_REPEAT_PERIOD;
        i_cfg_wdata <= period;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        for (int n = 0; n < LINE_MAX; n++) line_model[n] = CH_SPACE;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: lower case insert, left, backspace at column zero, delete,
        // right, modifiers, rejected character, then Return readout
        push_req(CMD_TICK, 16'hffff);
        push_req(CMD_BEGIN, 16'hffff);
        press_key(KEY_Z_LOWER, 1);
        press_key(K_LEFT, 1);
        press_key(K_BACKSPACE, 1);
        press_key(K_DELETE, 1);
        press_key(K_RIGHT, 1);
        push_req(CMD_KEY_DOWN, K_LSHIFT);
        push_req(CMD_KEY_UP, K_RCTRL);
        press_key(KEY_QUERY, 1);
        press_key(K_RETURN, 1);
        wait_idle();

        set_regs(8'hff, 8'd0, 8'd0);
        random_phase(70);
        // leave a long line open so the next, shorter setting strands the cursor
        push_req(CMD_BEGIN, '0);
        repeat (6) press_key(16'(CH_LOWER_A) + 16'($urandom_range(0, 25)), 1);
        wait_idle();

        set_regs(8'd4, 8'd2, 8'd1);
        random_phase(60);
        wait_idle();

        set_regs(8'd0, 8'd255, 8'd255);
        random_phase(40);
        wait_idle();

        set_regs(8'd1, 8'd1, 8'd0);
        random_phase(50);
        wait_idle();

        set_regs(8'd64, 8'd0, 8'd3);
        random_phase(60);
        wait_idle();

        set_regs(8'd13, 8'd3, 8'd2);
        quiet = 1'b1;
        random_phase(80);
        wait_idle();

        repeat (100) @(negedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
